### hw/rtl/ibma_pkg.sv
package ibma_pkg;

    // Table geometry
    localparam int MAX_SLOTS = 1024;
    localparam int WORD_W    = 32;
    localparam int WORDS     = MAX_SLOTS / WORD_W;
    localparam int WIDX_W    = $clog2(WORDS);
    localparam int BIT_W     = $clog2(WORD_W);
    localparam int SLOT_W    = $clog2(MAX_SLOTS);
    localparam int CNT_W     = 11;

    // Field widths
    localparam int ADDR_W    = 31;
    localparam int SIZE_W    = 13;
    localparam int STAT_W    = 3;
    localparam int PROD_W    = SLOT_W + SIZE_W;
    localparam int CFG_IDX_W = 2;

    typedef logic [STAT_W-1:0] t_status;

    localparam t_status ST_OK           = 3'd0;
    localparam t_status ST_NONE_FREE    = 3'd1;
    localparam t_status ST_MISALIGNED   = 3'd2;
    localparam t_status ST_OUT_OF_RANGE = 3'd3;
    localparam t_status ST_NOT_IN_USE   = 3'd4;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_BASE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT = 2'd2;

    localparam logic [ADDR_W-1:0] RST_BASE  = '0;
    localparam logic [SIZE_W-1:0] RST_SIZE  = 13'd128;
    localparam logic [CNT_W-1:0]  RST_COUNT = 11'd1024;

endpackage

### hw/rtl/ibma_ram.sv
module ibma_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

### hw/rtl/ibma_div.sv
module ibma_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [ibma_pkg::ADDR_W-1:0] i_dividend,
    input  logic [ibma_pkg::SIZE_W-1:0] i_divisor,
    output logic                        o_done,
    output logic [ibma_pkg::ADDR_W-1:0] o_quotient,
    output logic [ibma_pkg::SIZE_W-1:0] o_remainder
);
    import ibma_pkg::*;

    localparam int STEP_W = $clog2(ADDR_W + 1);

    logic              r_busy;
    logic [STEP_W-1:0] r_step;
    logic [ADDR_W-1:0] r_quo;
    logic [SIZE_W-1:0] r_rem;
    logic [SIZE_W-1:0] r_dsr;
    logic              r_done;

    logic [SIZE_W:0]   shifted;
    logic              fits;
    logic [SIZE_W:0]   diff;

    // one restoring step per cycle, quotient shifts in from the bottom
    always_comb begin
        shifted = {r_rem, r_quo[ADDR_W-1]};
        fits    = shifted >= {1'b0, r_dsr};
        diff    = shifted - {1'b0, r_dsr};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                if (r_step == STEP_W'(ADDR_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_step <= r_step + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[ADDR_W-2:0], fits};
            r_rem <= fits ? diff[SIZE_W-1:0] : shifted[SIZE_W-1:0];
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

### hw/rtl/inode_bitmap_allocator.sv
// First-free slot allocator over a used-bit map.
//
// Requests arrive on the s_axis channel: tuser carries the opcode (0 allocate,
// 1 free) and tdata the byte address to free. Each request gives one result
// on the m_axis channel: tuser carries the status, tdata the allocated slot
// address and the free slot count after the request.
// Registers (base, size, count) are written through the cfg channel, which
// is always ready; write them only while no request is in flight.
//
// An allocate scans the used map one 32-bit word per cycle through the map
// RAM read port. A free runs the 31-step iterative divider that turns the
// offset into a slot number, then one read of the map and, if the slot is
// in use, one write.
// One request is worked on at a time; s_axis_tready is high only while idle.
// A finished result sits in the output register until taken; a new request
// is accepted meanwhile, but its result waits until the register is free.
// Reset restores the register defaults, marks every slot free by clearing
// one valid bit per map word (no clearing pass), and empties the output.
module inode_bitmap_allocator (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // request: tdata = address[30:0], zero pad[31]; tuser = opcode
    input  logic                         i_s_axis_tvalid,
    output logic                         o_s_axis_tready,
    input  logic [31:0]                  i_s_axis_tdata,
    input  logic                         i_s_axis_tuser,
    // result: tdata = slot_address[30:0], free_slots[41:31], zero pad[47:42];
    // tuser = status
    output logic                         o_m_axis_tvalid,
    input  logic                         i_m_axis_tready,
    output logic [47:0]                  o_m_axis_tdata,
    output logic [ibma_pkg::STAT_W-1:0]  o_m_axis_tuser,
    // register writes
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [ibma_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ibma_pkg::ADDR_W-1:0]   i_cfg_data
);
    import ibma_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_AWRITE = 3'd2;
    localparam logic [2:0] S_AMUL   = 3'd3;
    localparam logic [2:0] S_FDIV   = 3'd4;
    localparam logic [2:0] S_FREAD  = 3'd5;
    localparam logic [2:0] S_FCHECK = 3'd6;
    localparam logic [2:0] S_DONE   = 3'd7;

    // configuration
    logic [ADDR_W-1:0] r_base;
    logic [SIZE_W-1:0] r_size;
    logic [CNT_W-1:0]  r_count;

    // control
    logic [2:0]        r_state;
    logic [CNT_W-1:0]  r_used;
    logic [WORDS-1:0]  r_wvalid;
    logic [WIDX_W-1:0] r_idx;
    logic              r_issue_done;
    logic              r_chk_valid;
    logic [WIDX_W-1:0] r_chk_idx;
    logic              r_rd_vld;
    logic              r_out_valid;

    // payload
    logic              r_op;
    t_status           r_status;
    logic [SLOT_W-1:0] r_slot;
    logic [WORD_W-1:0] r_word;
    logic [PROD_W-1:0] r_prod;
    logic [47:0]       r_out_data;
    t_status           r_out_user;

    // derived values
    logic [CNT_W-1:0]  eff_count;
    logic [SIZE_W-1:0] eff_size;
    logic [CNT_W-1:0]  free_now;
    logic [ADDR_W:0]   addr_sum;

    // map RAM
    logic              ram_we;
    logic [WIDX_W-1:0] ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic [WIDX_W-1:0] ram_raddr;
    logic [WORD_W-1:0] ram_q;
    logic [WORD_W-1:0] map_word;

    // scan
    logic [WORD_W-1:0] free_vec;
    logic [BIT_W-1:0]  free_bit;
    logic              free_any;
    logic [SLOT_W-1:0] glob_idx;

    // divider
    logic              div_start;
    logic              div_done;
    logic [ADDR_W-1:0] div_quo;
    logic [SIZE_W-1:0] div_rem;

    logic              in_xfer;
    logic              out_load;

    assign in_xfer     = i_s_axis_tvalid && o_s_axis_tready;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        eff_count = (r_count > CNT_W'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS) : r_count;
        eff_size  = (r_size == '0) ? SIZE_W'(1) : r_size;
        free_now  = (eff_count > r_used) ? (eff_count - r_used) : '0;
        addr_sum  = {1'b0, r_base} + (ADDR_W + 1)'(r_prod);
    end

    // Never-written words read as all free.
    assign map_word = r_rd_vld ? ram_q : '0;

    // Free bits of the checked word that lie below the effective count.
    always_comb begin
        free_bit = '0;
        free_any = 1'b0;
        glob_idx = '0;
        for (int b = 0; b < WORD_W; b++) begin
            glob_idx    = {r_chk_idx, BIT_W'(b)};
            free_vec[b] = !map_word[b] && (CNT_W'(glob_idx) < eff_count);
        end
        for (int b = WORD_W - 1; b >= 0; b--) begin
            if (free_vec[b]) begin
                free_bit = BIT_W'(b);
                free_any = 1'b1;
            end
        end
    end

    // Map RAM addressing: scan counter during an allocate, slot word otherwise.
    always_comb begin
        ram_raddr = (r_state == S_SCAN) ? r_idx : r_slot[SLOT_W-1:BIT_W];
        ram_we    = 1'b0;
        ram_waddr = r_slot[SLOT_W-1:BIT_W];
        ram_wdata = r_word | (WORD_W'(1) << r_slot[BIT_W-1:0]);
        if (r_state == S_AWRITE) begin
            ram_we = 1'b1;
        end else if (r_state == S_FCHECK && map_word[r_slot[BIT_W-1:0]]) begin
            ram_we    = 1'b1;
            ram_wdata = map_word & ~(WORD_W'(1) << r_slot[BIT_W-1:0]);
        end
    end

    ibma_ram #(
        .WIDTH (WORD_W),
        .DEPTH (WORDS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_q)
    );

    assign div_start = in_xfer && (i_s_axis_tuser == OP_FREE)
                       && (i_s_axis_tdata[ADDR_W-1:0] >= r_base);

    ibma_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (i_s_axis_tdata[ADDR_W-1:0] - r_base),
        .i_divisor   (eff_size),
        .o_done      (div_done),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    assign out_load = (r_state == S_DONE) && (!r_out_valid || i_m_axis_tready);

    // Configuration registers; writes beyond the list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base  <= RST_BASE;
            r_size  <= RST_SIZE;
            r_count <= RST_COUNT;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_BASE:  r_base  <= i_cfg_data;
                REG_SIZE:  r_size  <= i_cfg_data[SIZE_W-1:0];
                REG_COUNT: r_count <= i_cfg_data[CNT_W-1:0];
                default:   ;
            endcase
        end
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_used       <= '0;
            r_wvalid     <= '0;
            r_idx        <= '0;
            r_issue_done <= 1'b0;
            r_chk_valid  <= 1'b0;
            r_chk_idx    <= '0;
            r_rd_vld     <= 1'b0;
        end else begin
            r_rd_vld <= r_wvalid[ram_raddr];
            if (ram_we) begin
                r_wvalid[ram_waddr] <= 1'b1;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        if (i_s_axis_tuser == OP_ALLOC) begin
                            r_idx        <= '0;
                            r_issue_done <= 1'b0;
                            r_chk_valid  <= 1'b0;
                            r_state      <= S_SCAN;
                        end else if (div_start) begin
                            r_state <= S_FDIV;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_SCAN: begin
                    // issue one word read a cycle, check the previous word
                    r_chk_valid <= !r_issue_done;
                    r_chk_idx   <= r_idx;
                    if (r_idx == WIDX_W'(WORDS - 1)) begin
                        r_issue_done <= 1'b1;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                    if (r_chk_valid && free_any) begin
                        r_state <= S_AWRITE;
                    end else if (r_chk_valid && r_chk_idx == WIDX_W'(WORDS - 1)) begin
                        r_state <= S_DONE;
                    end
                end
                S_AWRITE: begin
                    r_used  <= r_used + 1'b1;
                    r_state <= S_AMUL;
                end
                S_AMUL: begin
                    r_state <= S_DONE;
                end
                S_FDIV: begin
                    if (div_done) begin
                        if (div_rem != '0 || div_quo >= ADDR_W'(eff_count)) begin
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_FREAD;
                        end
                    end
                end
                S_FREAD: begin
                    r_state <= S_FCHECK;
                end
                S_FCHECK: begin
                    if (map_word[r_slot[BIT_W-1:0]] && r_used != '0) begin
                        r_used <= r_used - 1'b1;
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Request payload and status
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    r_op     <= i_s_axis_tuser;
                    r_status <= (i_s_axis_tuser == OP_FREE && !div_start)
                                ? ST_OUT_OF_RANGE : ST_OK;
                end
            end
            S_SCAN: begin
                if (r_chk_valid && free_any) begin
                    r_slot <= {r_chk_idx, free_bit};
                    r_word <= map_word;
                end else if (r_chk_valid && r_chk_idx == WIDX_W'(WORDS - 1)) begin
                    r_status <= ST_NONE_FREE;
                end
            end
            S_AMUL: begin
                r_prod <= PROD_W'(r_slot) * PROD_W'(eff_size);
            end
            S_FDIV: begin
                if (div_done) begin
                    r_slot <= div_quo[SLOT_W-1:0];
                    if (div_rem != '0) begin
                        r_status <= ST_MISALIGNED;
                    end else if (div_quo >= ADDR_W'(eff_count)) begin
                        r_status <= ST_OUT_OF_RANGE;
                    end
                end
            end
            S_FCHECK: begin
                if (!map_word[r_slot[BIT_W-1:0]]) begin
                    r_status <= ST_NOT_IN_USE;
                end
            end
            default: ;
        endcase
    end

    // Output register: hold the result until the receiver takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_user <= r_status;
            r_out_data <= {6'd0, free_now,
                           (r_op == OP_ALLOC && r_status == ST_OK)
                               ? addr_sum[ADDR_W-1:0] : ADDR_W'(0)};
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;

endmodule
